[rtl/mtxq_pkg.sv]
// Mutex unit package: status and action codes, default sizes.
// No dependencies.
package mtxq_pkg;
	localparam int LOCKS_DEF       = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [1:0] ACT_INIT    = 2'd0;
	localparam logic [1:0] ACT_ACQUIRE = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [2:0] ST_INDEX   = 3'd0;
	localparam logic [2:0] ST_GRANTED = 3'd1;
	localparam logic [2:0] ST_QUEUED  = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_QFULL   = 3'd5;

	localparam logic [8:0] OWNER_NONE = 9'h1FF;
endpackage

[rtl/mutex_unit_with_wait_queues.sv]
// Mutex unit with FIFO wait queues: top level.
// Depends on mtxq_pkg.
//
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high and cannot be held off. Init walks the key
// table one entry per cycle. Acquire and release go through accept, the
// waiter memory read, then update and result. An out-of-range index or an
// unknown action is answered at once from the idle state. The lock state is
// kept in a per-lock register row with reset values, the waiters in a
// synchronous memory whose entries hold anything until written.
module mutex_unit_with_wait_queues
	import mtxq_pkg::*;
#(
	parameter int LOCKS       = LOCKS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic signed [31:0] lock_key,
	input  logic [5:0]        lock_index,
	input  logic [7:0]        task_id,
	output logic              done,
	output logic [2:0]        status,
	output logic [3:0]        result_index,
	output logic              woken_valid,
	output logic [7:0]        woken_task,
	output logic signed [8:0] owner_after
);
	localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = LW + QW;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_WAIT, S_DONE} state_t;
	state_t state_q;

	// Per-lock state
	logic [31:0]   key_q   [LOCKS];
	logic          lkd_q   [LOCKS];
	logic [8:0]    own_q   [LOCKS];
	logic [QW-1:0] head_q  [LOCKS];
	logic [QW-1:0] tail_q  [LOCKS];
	logic [CW-1:0] cnt_q   [LOCKS];

	// Waiter memory, addressed by {lock, slot}
	logic [7:0] wmem [2**SW];
	logic [7:0] wrd_q;

	// Request registers
	logic [1:0]    act_q;
	logic [31:0]   key_req_q;
	logic [LW-1:0] idx_q;
	logic [7:0]    task_q;
	logic [LW:0]   scan_q;
	logic          match_f_q, free_f_q;
	logic [LW-1:0] match_i_q, free_i_q;

	logic [LW-1:0] scan_i;
	assign scan_i = scan_q[LW-1:0];
	assign busy = (state_q != S_IDLE);

	// Read waiter at head of the addressed queue; write a queued task at its tail
	always_ff @(posedge clk) begin
		if (state_q == S_READ)
			wrd_q <= wmem[{idx_q, head_q[idx_q]}];
		if (state_q == S_WAIT && act_q == ACT_ACQUIRE && lkd_q[idx_q] &&
			cnt_q[idx_q] < CW'(QUEUE_DEPTH))
			wmem[SW'({idx_q, tail_q[idx_q]})] <= task_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			status <= ST_IGNORED;
			result_index <= '0;
			woken_valid <= 1'b0;
			woken_task <= '0;
			owner_after <= OWNER_NONE;
			for (int i = 0; i < LOCKS; i++) begin
				key_q[i] <= '0;
				lkd_q[i] <= 1'b0;
				own_q[i] <= OWNER_NONE;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			act_q <= '0; key_req_q <= '0; idx_q <= '0; task_q <= '0;
			scan_q <= '0; match_f_q <= 1'b0; free_f_q <= 1'b0;
			match_i_q <= '0; free_i_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= action;
						key_req_q <= lock_key;
						idx_q <= lock_index[LW-1:0];
						task_q <= task_id;
						scan_q <= '0;
						match_f_q <= 1'b0;
						free_f_q <= 1'b0;
						if (action == ACT_INIT)
							state_q <= S_SCAN;
						else if ((action == ACT_ACQUIRE || action == ACT_RELEASE) &&
							32'(lock_index) < 32'(LOCKS))
							state_q <= S_READ;
						else begin
							// Ignore out-of-range index or unknown action
							done <= 1'b1;
							status <= ST_IGNORED;
							result_index <= '0;
							woken_valid <= 1'b0;
							woken_task <= '0;
							owner_after <= OWNER_NONE;
						end
					end
				end
				S_SCAN: begin
					// Walk the key table, one entry per cycle
					if (scan_q < (LW+1)'(LOCKS)) begin
						if (!match_f_q && key_q[scan_i] == key_req_q) begin
							match_f_q <= 1'b1; match_i_q <= scan_i;
						end
						if (!free_f_q && key_q[scan_i] == '0) begin
							free_f_q <= 1'b1; free_i_q <= scan_i;
						end
						scan_q <= scan_q + 1'b1;
					end else begin
						done <= 1'b1;
						woken_valid <= 1'b0;
						woken_task <= '0;
						state_q <= S_IDLE;
						if (match_f_q) begin
							status <= ST_INDEX;
							result_index <= 4'(match_i_q);
							owner_after <= own_q[match_i_q];
						end else if (free_f_q) begin
							// Claim the first free entry
							key_q[free_i_q] <= key_req_q;
							lkd_q[free_i_q] <= 1'b0;
							own_q[free_i_q] <= OWNER_NONE;
							head_q[free_i_q] <= '0;
							tail_q[free_i_q] <= '0;
							cnt_q[free_i_q] <= '0;
							status <= ST_INDEX;
							result_index <= 4'(free_i_q);
							owner_after <= OWNER_NONE;
						end else begin
							status <= ST_FULL;
							result_index <= '0;
							owner_after <= OWNER_NONE;
						end
					end
				end
				S_READ: state_q <= S_WAIT;
				S_WAIT: begin
					done <= 1'b1;
					result_index <= '0;
					woken_valid <= 1'b0;
					woken_task <= '0;
					owner_after <= own_q[idx_q];
					state_q <= S_IDLE;
					if (act_q == ACT_ACQUIRE) begin
						if (!lkd_q[idx_q]) begin
							lkd_q[idx_q] <= 1'b1;
							own_q[idx_q] <= {1'b0, task_q};
							owner_after <= {1'b0, task_q};
							status <= ST_GRANTED;
						end else if (cnt_q[idx_q] < CW'(QUEUE_DEPTH)) begin
							tail_q[idx_q] <= (tail_q[idx_q] == QW'(QUEUE_DEPTH-1)) ?
								'0 : tail_q[idx_q] + 1'b1;
							cnt_q[idx_q] <= cnt_q[idx_q] + 1'b1;
							status <= ST_QUEUED;
						end else
							status <= ST_QFULL;
					end else begin
						status <= ST_GRANTED;
						if (cnt_q[idx_q] == '0) begin
							own_q[idx_q] <= OWNER_NONE;
							lkd_q[idx_q] <= 1'b0;
							owner_after <= OWNER_NONE;
						end else begin
							// Hand the lock to the oldest waiter
							head_q[idx_q] <= (head_q[idx_q] == QW'(QUEUE_DEPTH-1)) ?
								'0 : head_q[idx_q] + 1'b1;
							cnt_q[idx_q] <= cnt_q[idx_q] - 1'b1;
							lkd_q[idx_q] <= 1'b1;
							own_q[idx_q] <= {1'b0, wrd_q};
							owner_after <= {1'b0, wrd_q};
							woken_valid <= 1'b1;
							woken_task <= wrd_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/mtxq_checker.sv]
// Port-level checker for the mutex unit, bound to the top level.
// Depends on mtxq_pkg.
module mtxq_checker
	import mtxq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic       woken_valid,
	input logic [7:0] woken_task
);
	// Accepted request makes the unit busy or answers at once
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("request not taken");
	// Wake only comes with a granted release
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_valid |-> status == ST_GRANTED) else $error("bad wake");
	// Status codes stay in range
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_QFULL) else $error("bad status");
	// No woken task without a wake
	a_wt: assert property (@(posedge clk) disable iff (!arst_n)
		done && !woken_valid |-> woken_task == 8'd0) else $error("stray task");
endmodule

bind mutex_unit_with_wait_queues mtxq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .woken_valid(woken_valid), .woken_task(woken_task)
);

[tb/sv/tb_mutex_unit_with_wait_queues.sv]
// Testbench for the mutex unit with FIFO wait queues: random and directed
// init/acquire/release requests checked against a predictor of the lock table.
// Depends on mtxq_pkg and mutex_unit_with_wait_queues.
module tb_mutex_unit_with_wait_queues;
	timeunit 1ns;
	timeprecision 1ps;
	import mtxq_pkg::*;

	localparam int NLOCK = LOCKS_DEF;
	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] lock_key;
		logic [5:0]  lock_index;
		logic [7:0]  task_id;
	} lock_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] result_index;
		logic       woken_valid;
		logic [7:0] woken_task;
		logic [8:0] owner_after;
	} lock_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] action = '0;
	logic signed [31:0] lock_key = '0;
	logic [5:0] lock_index = '0;
	logic [7:0] task_id = '0;
	logic busy, done, woken_valid;
	logic [2:0] status;
	logic [3:0] result_index;
	logic [7:0] woken_task;
	logic signed [8:0] owner_after;

	// predictor copy of the lock table
	logic [31:0] key_tab [NLOCK];
	logic        locked_tab [NLOCK];
	logic [8:0]  owner_tab [NLOCK];
	logic [7:0]  waiters [NLOCK][QDEPTH];
	int          q_head [NLOCK];
	int          q_tail [NLOCK];
	int          q_count [NLOCK];

	lock_req_t  pending_reqs [$];
	lock_resp_t expected_resps [$];
	int errors = 0;
	bit drain_hold = 1'b0;
	int gap = 0;

	mutex_unit_with_wait_queues DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic lock_resp_t predict_lock(lock_req_t r);
		lock_resp_t o;
		bit found;
		int i;
		o = '{status: ST_IGNORED, result_index: 4'd0, woken_valid: 1'b0,
			woken_task: 8'd0, owner_after: OWNER_NONE};
		found = 1'b0;
		if (r.action == ACT_INIT) begin
			for (i = 0; i < NLOCK && !found; i++)
				if (key_tab[i] == r.lock_key) begin
					found = 1'b1;
					o.result_index = 4'(i);
				end
			for (i = 0; i < NLOCK && !found; i++)
				if (key_tab[i] == 32'd0) begin
					found = 1'b1;
					o.result_index = 4'(i);
					key_tab[i] = r.lock_key;
					locked_tab[i] = 1'b0;
					owner_tab[i] = OWNER_NONE;
					q_head[i] = 0;
					q_tail[i] = 0;
					q_count[i] = 0;
				end
			if (found) begin
				o.status = ST_INDEX;
				o.owner_after = owner_tab[o.result_index];
			end else
				o.status = ST_FULL;
		end else if ((r.action == ACT_ACQUIRE || r.action == ACT_RELEASE)
				&& r.lock_index < NLOCK) begin
			i = int'(r.lock_index);
			if (r.action == ACT_ACQUIRE) begin
				if (!locked_tab[i]) begin
					locked_tab[i] = 1'b1;
					owner_tab[i] = {1'b0, r.task_id};
					o.status = ST_GRANTED;
				end else if (q_count[i] < QDEPTH) begin
					waiters[i][q_tail[i]] = r.task_id;
					q_tail[i] = (q_tail[i] + 1) % QDEPTH;
					q_count[i]++;
					o.status = ST_QUEUED;
				end else
					o.status = ST_QFULL;
			end else begin
				if (q_count[i] == 0) begin
					owner_tab[i] = OWNER_NONE;
					locked_tab[i] = 1'b0;
				end else begin
					o.woken_task = waiters[i][q_head[i]];
					o.woken_valid = 1'b1;
					q_head[i] = (q_head[i] + 1) % QDEPTH;
					q_count[i]--;
					locked_tab[i] = 1'b1;
					owner_tab[i] = {1'b0, o.woken_task};
				end
				o.status = ST_GRANTED;
			end
			o.owner_after = owner_tab[i];
		end
		return o;
	endfunction

	function automatic lock_req_t make_req(logic [1:0] a, logic [31:0] k,
			logic [5:0] idx, logic [7:0] t);
		lock_req_t r;
		r.action = a;
		r.lock_key = k;
		r.lock_index = idx;
		r.task_id = t;
		return r;
	endfunction

	// driver: hold start until accepted, then wait a random gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_resps.push_back(predict_lock(pending_reqs.pop_front()));
				start <= 1'b0;
				gap = $urandom_range(0, 4);
			end else if (!start) begin
				if (gap > 0)
					gap--;
				else if (pending_reqs.size() > 0 && !drain_hold) begin
					action <= pending_reqs[0].action;
					lock_key <= pending_reqs[0].lock_key;
					lock_index <= pending_reqs[0].lock_index;
					task_id <= pending_reqs[0].task_id;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		lock_resp_t e;
		if (arst_n && done) begin
			if (expected_resps.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = expected_resps.pop_front();
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status);
					errors++;
				end
				if (result_index !== e.result_index) begin
					$error("result_index exp %0d got %0d", e.result_index, result_index);
					errors++;
				end
				if (woken_valid !== e.woken_valid) begin
					$error("woken_valid exp %0d got %0d", e.woken_valid, woken_valid);
					errors++;
				end
				if (woken_task !== e.woken_task) begin
					$error("woken_task exp %0d got %0d", e.woken_task, woken_task);
					errors++;
				end
				if (owner_after !== e.owner_after) begin
					$error("owner_after exp %0d got %0d", $signed(e.owner_after),
						owner_after);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int i, n, idx, k;
		logic [31:0] keys [8];
		for (i = 0; i < NLOCK; i++) begin
			key_tab[i] = '0;
			locked_tab[i] = 1'b0;
			owner_tab[i] = OWNER_NONE;
			q_head[i] = 0;
			q_tail[i] = 0;
			q_count[i] = 0;
		end
		// directed: init extremes, key zero, grant, queue, handoff, free release
		pending_reqs.push_back(make_req(ACT_INIT, 32'd0, 6'd0, 8'd0));
		pending_reqs.push_back(make_req(ACT_INIT, 32'h8000_0000, 6'd0, 8'd0));
		pending_reqs.push_back(make_req(ACT_INIT, 32'h7FFF_FFFF, 6'd63, 8'd255));
		pending_reqs.push_back(make_req(ACT_INIT, 32'hFFFF_FFFF, 6'd0, 8'd0));
		pending_reqs.push_back(make_req(ACT_INIT, 32'h8000_0000, 6'd0, 8'd0));
		pending_reqs.push_back(make_req(ACT_ACQUIRE, 32'd0, 6'd0, 8'd255));
		pending_reqs.push_back(make_req(ACT_ACQUIRE, 32'd0, 6'd0, 8'd255));
		pending_reqs.push_back(make_req(ACT_ACQUIRE, 32'd0, 6'd0, 8'd0));
		pending_reqs.push_back(make_req(ACT_RELEASE, 32'd0, 6'd0, 8'd7));
		pending_reqs.push_back(make_req(ACT_RELEASE, 32'd0, 6'd0, 8'd7));
		pending_reqs.push_back(make_req(ACT_RELEASE, 32'd0, 6'd0, 8'd7));
		pending_reqs.push_back(make_req(ACT_RELEASE, 32'd0, 6'd15, 8'd0));
		pending_reqs.push_back(make_req(ACT_ACQUIRE, 32'd0, 6'd16, 8'd1));
		pending_reqs.push_back(make_req(ACT_RELEASE, 32'd0, 6'd63, 8'd1));
		pending_reqs.push_back(make_req(ACT_UNKNOWN, 32'hFFFF_FFFF, 6'd2, 8'd3));
		// fill one queue past its depth
		for (i = 0; i < QDEPTH + 2; i++)
			pending_reqs.push_back(make_req(ACT_ACQUIRE, 32'd0, 6'd5, 8'(i * 13)));
		// fill the table, then further fresh keys get table full
		for (i = 0; i < NLOCK + 1; i++)
			pending_reqs.push_back(make_req(ACT_INIT, 32'(32'h100 + i), 6'd0, 8'd0));
		// drain the directed part fully before random traffic
		wait (arst_n);
		wait (pending_reqs.size() == 0 && expected_resps.size() == 0 && !start);
		drain_hold = 1'b1;
		repeat (40) @(posedge clk);
		// random: mostly acquire/release on valid locks, some init and noise
		for (i = 0; i < 8; i++)
			keys[i] = (i == 0) ? 32'd0 : $urandom();
		for (n = 0; n < 1560; n++) begin
			k = $urandom_range(0, 99);
			idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, 3) + 4 * $urandom_range(0, 3);
			if (k < 10)
				pending_reqs.push_back(make_req(ACT_INIT,
					($urandom_range(0, 3) == 0) ? $urandom() : keys[$urandom_range(0, 7)],
					6'($urandom()), 8'($urandom())));
			else if (k < 55)
				pending_reqs.push_back(make_req(ACT_ACQUIRE, $urandom(), 6'(idx),
					8'($urandom())));
			else if (k < 97)
				pending_reqs.push_back(make_req(ACT_RELEASE, $urandom(), 6'(idx),
					8'($urandom())));
			else
				pending_reqs.push_back(make_req(ACT_UNKNOWN, $urandom(), 6'($urandom()),
					8'($urandom())));
		end
		drain_hold = 1'b0;
		wait (pending_reqs.size() == 0 && expected_resps.size() == 0 && !start);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("mutex_unit_with_wait_queues regression: pass");
		else
			$display("mutex_unit_with_wait_queues regression: fail");
		$finish;
	end

	// hold reset at start, then release it on a clock edge
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// guard against a hang
	initial begin
		#3_000_000;
		$display("mutex_unit_with_wait_queues regression: fail");
		$finish;
	end
endmodule

[filelist.f]
rtl/mtxq_pkg.sv
rtl/mutex_unit_with_wait_queues.sv
rtl/mtxq_checker.sv
tb/sv/tb_mutex_unit_with_wait_queues.sv
